// File: design/ssn_pkg.sv
// Package for the selectable static nonlinearity core.
// Types, widths, register codes and defaults shared by all core files; no dependencies.
`default_nettype none
package ssn_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 47;
    localparam int LEVEL_W   = 32;
    localparam int GAIN_W    = 40;
    localparam int CUT_W     = 23;
    localparam int CAP_W     = 61;
    localparam int LOGI_W    = 31;
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int NUM_STAGES = 14;

    localparam int IN_FRAC_BITS_DEF    = 20;
    localparam int SIG_TABLE_DEPTH_DEF = 1024;
    localparam int SIG_IN_RANGE_DEF    = 16;

    localparam logic [CAP_W-1:0]  WIDE_CAP = CAP_W'(1) << 60;
    localparam logic [LOGI_W-1:0] LOGI_ONE = LOGI_W'(1) << 30;

    typedef enum logic [2:0] {
        MODE_SQUARE,
        MODE_SAT_SQUARE,
        MODE_DBL_LOGI,
        MODE_SQ_LOGI,
        MODE_LINEAR,
        MODE_SAT_LINEAR,
        MODE_BOX,
        MODE_SCALE
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_LEVEL_MIN,
        REG_LEVEL_MAX,
        REG_CUT_LEVEL,
        REG_GAIN,
        REG_SIG_SLOPE,
        REG_SIG_SHIFT,
        REG_SIG_OFFSET
    } reg_idx_t;

    typedef struct packed {
        mode_t                      mode;
        logic signed [LEVEL_W-1:0]  level_min;
        logic signed [LEVEL_W-1:0]  level_max;
        logic [CUT_W-1:0]           cut_level;
        logic [GAIN_W-1:0]          gain;
        logic [GAIN_W-1:0]          sig_slope;
        logic [CUT_W-1:0]           sig_shift;
        logic signed [LEVEL_W-1:0]  sig_offset;
    } cfg_t;

    typedef struct packed {
        logic neg;
        logic d1neg;
        logic d2pos;
        logic below_cut;
    } flags_t;

    typedef logic [NUM_STAGES:1] stage_en_t;

endpackage
`default_nettype wire

// File: design/ssn_sig_rom.sv
// Logistic lookup table, built at elaboration, with registered read.
// Each word holds two neighboring Q30 entries {T[i+1], T[i]}. Uses ssn_pkg.
`default_nettype none
module ssn_sig_rom #(
    parameter int SIG_TABLE_DEPTH = ssn_pkg::SIG_TABLE_DEPTH_DEF,
    parameter int SIG_IN_RANGE    = ssn_pkg::SIG_IN_RANGE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(SIG_TABLE_DEPTH)-1:0]   addr,
    output logic [2*ssn_pkg::LOGI_W-1:0]              data
);

    localparam int DW = 2 * ssn_pkg::LOGI_W;

    typedef logic [DW-1:0] rom_t [SIG_TABLE_DEPTH];

    // shift and subtract long division, used only while building the table
    function automatic logic [63:0] cdiv(logic [63:0] num, logic [63:0] dvs);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs})
            begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic rom_t build_table();
        logic [63:0]  t;
        logic [63:0]  step;
        logic [63:0]  cur;
        logic [63:0]  den;
        logic [127:0] prod;
        logic [63:0]  logi [SIG_TABLE_DEPTH+1];
        rom_t         tbl;
        bit           sub;
        t    = 64'd1 << 56;
        step = t;
        cur  = t;
        sub  = 1'b1;
        // alternating series for e^-h, h = one table step
        for (int k = 1; k <= 40; k++) begin
            t = cdiv(t * 64'(SIG_IN_RANGE), 64'(SIG_TABLE_DEPTH) * 64'(k));
            if (sub)
                step = step - t;
            else
                step = step + t;
            sub = !sub;
        end
        for (int i = 0; i <= SIG_TABLE_DEPTH; i++) begin
            den     = (64'd1 << 32) + (cur >> 24);
            logi[i] = cdiv((64'd1 << 62) + (den >> 1), den);
            prod    = (128'(cur) * 128'(step)) >> 56;
            cur     = (prod > 128'(ssn_pkg::WIDE_CAP)) ? 64'(ssn_pkg::WIDE_CAP) : prod[63:0];
        end
        for (int i = 0; i < SIG_TABLE_DEPTH; i++)
            tbl[i] = {logi[i+1][ssn_pkg::LOGI_W-1:0], logi[i][ssn_pkg::LOGI_W-1:0]};
        return tbl;
    endfunction

    localparam rom_t TABLE = build_table();

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data <= TABLE[addr];
    end

endmodule
`default_nettype wire

// File: design/ssn_sig_lane.sv
// One logistic evaluation lane: index/fraction from a Q16 argument, table read,
// linear interpolation and mirror for negative arguments. Stages 6 to 11. Uses ssn_pkg, ssn_sig_rom.
`default_nettype none
module ssn_sig_lane #(
    parameter int SIG_TABLE_DEPTH = ssn_pkg::SIG_TABLE_DEPTH_DEF,
    parameter int SIG_IN_RANGE    = ssn_pkg::SIG_IN_RANGE_DEF
) (
    input  wire logic                          clk,
    input  wire ssn_pkg::stage_en_t            en,
    input  wire logic [ssn_pkg::CAP_W-1:0]     u,
    input  wire logic                          neg,
    output logic [ssn_pkg::LOGI_W-1:0]         l
);

    localparam int UB = $clog2(SIG_IN_RANGE * 65536);
    localparam int DB = $clog2(SIG_TABLE_DEPTH + 1);
    localparam int NW = UB + DB;
    localparam int AW = $clog2(SIG_TABLE_DEPTH);
    localparam int IW = NW - 16;
    localparam int LW = ssn_pkg::LOGI_W;
    localparam logic [NW-1:0] MUL = NW'((longint'(1) << NW) / SIG_IN_RANGE);
    localparam logic [ssn_pkg::CAP_W-1:0] U_LIMIT = ssn_pkg::CAP_W'(SIG_IN_RANGE) << 16;

    // stage 6
    logic [NW-1:0] n6_reg, n6_next;
    logic          big6_reg, neg6_reg;
    // stage 7
    logic [NW-1:0] n7_reg, q7_reg;
    logic [2*NW-1:0] prod7;
    logic          big7_reg, neg7_reg;
    // stage 8
    logic [NW-1:0] qr8, r8, pos8;
    logic [IW-1:0] idx8;
    logic [AW-1:0] addr8_reg, addr8_next;
    logic [15:0]   frac8_reg;
    logic          big8_reg, neg8_reg;
    // stage 9
    logic [2*LW-1:0] data9;
    logic [15:0]   frac9_reg;
    logic          big9_reg, neg9_reg;
    // stage 10
    logic [LW-1:0] a10, b10, diff10;
    logic [LW+15:0] prod10;
    logic [LW-1:0] a10_reg, b10_reg, p10_reg;
    logic          up10_reg, big10_reg, neg10_reg;
    // stage 11
    logic [LW-1:0] v11, l11_reg, l11_next;

    assign n6_next = NW'(u[UB-1:0]) * NW'(SIG_TABLE_DEPTH);
    assign prod7   = n6_reg * MUL;

    always_comb
    begin
        // quotient estimate is low by at most one
        qr8  = q7_reg * NW'(SIG_IN_RANGE);
        r8   = n7_reg - qr8;
        pos8 = (r8 >= NW'(SIG_IN_RANGE)) ? q7_reg + NW'(1) : q7_reg;
        idx8 = pos8[NW-1:16];
        // beyond the table range: point at the last pair so the upper word is the last entry
        addr8_next = (big7_reg || idx8 >= IW'(SIG_TABLE_DEPTH)) ?
                     AW'(SIG_TABLE_DEPTH - 1) : idx8[AW-1:0];
    end

    always_comb
    begin
        a10    = data9[LW-1:0];
        b10    = data9[2*LW-1:LW];
        diff10 = (b10 >= a10) ? b10 - a10 : a10 - b10;
        prod10 = diff10 * frac9_reg;
    end

    always_comb
    begin
        // beyond the table range: hold the last entry
        if (big10_reg)
            v11 = b10_reg;
        else if (up10_reg)
            v11 = a10_reg + p10_reg;
        else
            v11 = a10_reg - p10_reg;
        l11_next = neg10_reg ? ssn_pkg::LOGI_ONE - v11 : v11;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            n6_reg   <= n6_next;
            big6_reg <= (u >= U_LIMIT);
            neg6_reg <= neg;
        end
        if (en[7])
        begin
            n7_reg   <= n6_reg;
            q7_reg   <= prod7[2*NW-1:NW];
            big7_reg <= big6_reg;
            neg7_reg <= neg6_reg;
        end
        if (en[8])
        begin
            addr8_reg <= addr8_next;
            frac8_reg <= pos8[15:0];
            big8_reg  <= big7_reg;
            neg8_reg  <= neg7_reg;
        end
        if (en[9])
        begin
            frac9_reg <= big8_reg ? 16'd0 : frac8_reg;
            big9_reg  <= big8_reg;
            neg9_reg  <= neg8_reg;
        end
        if (en[10])
        begin
            a10_reg   <= a10;
            b10_reg   <= b10;
            p10_reg   <= prod10[LW+15:16];
            up10_reg  <= (b10 >= a10);
            big10_reg <= big9_reg;
            neg10_reg <= neg9_reg;
        end
        if (en[11])
            l11_reg <= l11_next;
    end

    ssn_sig_rom #(
        .SIG_TABLE_DEPTH (SIG_TABLE_DEPTH),
        .SIG_IN_RANGE    (SIG_IN_RANGE)
    ) u_rom (
        .clk   (clk),
        .rd_en (en[9]),
        .addr  (addr8_reg),
        .data  (data9)
    );

    assign l = l11_reg;

endmodule
`default_nettype wire

// File: design/ssn_front.sv
// Front stages 1 to 5: magnitude, shifted differences, the square, the linear products
// and the wide saturated product gain*x^2 or slope*x^2. Uses ssn_pkg.
`default_nettype none
module ssn_front #(
    parameter int IN_FRAC_BITS = ssn_pkg::IN_FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire ssn_pkg::stage_en_t                    en,
    input  wire ssn_pkg::cfg_t                         cfg,
    input  wire logic signed [ssn_pkg::SAMPLE_W-1:0]   sample,
    output logic [ssn_pkg::CAP_W-1:0]                  wsat,
    output logic [ssn_pkg::CAP_W-1:0]                  u1,
    output logic [ssn_pkg::CAP_W-1:0]                  u2,
    output logic [ssn_pkg::CAP_W-1:0]                  lin,
    output ssn_pkg::flags_t                            flags
);

    localparam int MW = ssn_pkg::MAG_W;
    localparam int CW = ssn_pkg::CAP_W;

    logic signed [ssn_pkg::SAMPLE_W-1:0] s1_reg;

    logic signed [MW:0] s_ext, sh_ext, d1, d2, m_abs, d1_abs, d2_abs;
    logic [MW-1:0]      mag2_reg, ad1_2_reg, ad2_2_reg;
    ssn_pkg::flags_t    fl2_next, fl2_reg, fl3_reg, fl4_reg, fl5_reg;

    logic [2*MW-1:0]    sq3_full;
    logic [ssn_pkg::SQ_W-1:0] sq3_reg;
    logic [63:0]        u1r3_reg, u2r3_reg, lin3_reg;

    logic [ssn_pkg::GAIN_W-1:0] xmul4;
    logic [63:0]        pl4_reg;
    logic [62:0]        ph4_reg;
    logic [CW-1:0]      u1_4_reg, u2_4_reg, lin4_reg;

    logic [87:0]        full5, shr5;
    logic [CW-1:0]      wsat5_reg, u1_5_reg, u2_5_reg, lin5_reg;

    always_comb
    begin
        s_ext  = (MW+1)'(s1_reg);
        sh_ext = $signed({2'b00, cfg.sig_shift});
        d1     = s_ext - sh_ext;
        d2     = s_ext + sh_ext;
        m_abs  = s_ext[MW] ? -s_ext : s_ext;
        d1_abs = d1[MW] ? -d1 : d1;
        d2_abs = d2[MW] ? -d2 : d2;
        fl2_next.neg       = s_ext[MW];
        fl2_next.d1neg     = d1[MW];
        fl2_next.d2pos     = !d2[MW] && (d2 != '0);
        fl2_next.below_cut = m_abs[MW-1:0] < MW'(cfg.cut_level);
    end

    assign sq3_full = mag2_reg * mag2_reg;
    assign xmul4    = (cfg.mode == ssn_pkg::MODE_SQ_LOGI) ? cfg.sig_slope : cfg.gain;

    always_comb
    begin
        full5 = (88'(ph4_reg) << 24) + 88'(pl4_reg);
        shr5  = full5 >> (2 * IN_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            s1_reg <= sample;
        if (en[2])
        begin
            mag2_reg  <= m_abs[MW-1:0];
            ad1_2_reg <= d1_abs[MW-1:0];
            ad2_2_reg <= d2_abs[MW-1:0];
            fl2_reg   <= fl2_next;
        end
        if (en[3])
        begin
            sq3_reg  <= sq3_full[ssn_pkg::SQ_W-1:0];
            u1r3_reg <= cfg.sig_slope * ad1_2_reg;
            u2r3_reg <= cfg.sig_slope * ad2_2_reg;
            lin3_reg <= cfg.gain * mag2_reg;
            fl3_reg  <= fl2_reg;
        end
        if (en[4])
        begin
            // split the wide product into two partial products
            pl4_reg  <= xmul4 * sq3_reg[23:0];
            ph4_reg  <= xmul4 * sq3_reg[ssn_pkg::SQ_W-1:24];
            u1_4_reg <= CW'(u1r3_reg >> IN_FRAC_BITS);
            u2_4_reg <= CW'(u2r3_reg >> IN_FRAC_BITS);
            lin4_reg <= CW'(lin3_reg >> IN_FRAC_BITS);
            fl4_reg  <= fl3_reg;
        end
        if (en[5])
        begin
            wsat5_reg <= (shr5 > 88'(ssn_pkg::WIDE_CAP)) ? ssn_pkg::WIDE_CAP : shr5[CW-1:0];
            u1_5_reg  <= u1_4_reg;
            u2_5_reg  <= u2_4_reg;
            lin5_reg  <= lin4_reg;
            fl5_reg   <= fl4_reg;
        end
    end

    assign wsat  = wsat5_reg;
    assign u1    = u1_5_reg;
    assign u2    = u2_5_reg;
    assign lin   = lin5_reg;
    assign flags = fl5_reg;

endmodule
`default_nettype wire

// File: design/ssn_back.sv
// Back stages 6 to 14: side data delay, logistic scaling by gain, mode
// selection with level offsets, and final 32-bit saturation. Uses ssn_pkg.
`default_nettype none
module ssn_back (
    input  wire logic                              clk,
    input  wire ssn_pkg::stage_en_t                en,
    input  wire ssn_pkg::cfg_t                     cfg,
    input  wire logic [ssn_pkg::CAP_W-1:0]         wsat,
    input  wire logic [ssn_pkg::CAP_W-1:0]         lin,
    input  wire ssn_pkg::flags_t                   flags,
    input  wire logic [ssn_pkg::LOGI_W-1:0]        l1,
    input  wire logic [ssn_pkg::LOGI_W-1:0]        l2,
    output logic signed [ssn_pkg::LEVEL_W-1:0]     level,
    output logic                                   clipped
);

    localparam int CW = ssn_pkg::CAP_W;
    localparam int LW = ssn_pkg::LEVEL_W;
    localparam logic signed [63:0] POS_LIM = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] NEG_LIM = -64'sh8000_0000;

    logic [CW-1:0]   wsat_pipe [6:12];
    logic [CW-1:0]   lin_pipe  [6:12];
    ssn_pkg::flags_t fl_pipe   [6:12];

    logic [31:0]     lsum12;
    logic [71:0]     gm12;
    logic [41:0]     gm12_reg;

    logic signed [63:0] lmin, lmax, loff, sq_v, lin_v, gm_v, acc13_next, acc13_reg;
    logic signed [LW-1:0] level14_reg, level14_next;
    logic            clip14_reg, clip14_next;

    always_comb
    begin
        lsum12 = (cfg.mode == ssn_pkg::MODE_DBL_LOGI) ? 32'(l1) + 32'(l2) : 32'(l1);
        gm12   = cfg.gain * lsum12;
    end

    always_comb
    begin
        lmin  = 64'(cfg.level_min);
        lmax  = 64'(cfg.level_max);
        loff  = 64'(cfg.sig_offset);
        sq_v  = $signed({3'b000, wsat_pipe[12]}) + lmin;
        lin_v = $signed({3'b000, lin_pipe[12]});
        gm_v  = $signed({22'd0, gm12_reg});
        case (cfg.mode)
            ssn_pkg::MODE_SQUARE:     acc13_next = sq_v;
            ssn_pkg::MODE_SAT_SQUARE: acc13_next = (sq_v > lmax) ? lmax : sq_v;
            ssn_pkg::MODE_DBL_LOGI,
            ssn_pkg::MODE_SQ_LOGI:    acc13_next = gm_v + loff + lmin;
            ssn_pkg::MODE_LINEAR:     acc13_next = lin_v + lmin;
            ssn_pkg::MODE_SAT_LINEAR: acc13_next = (lin_v + lmin > lmax) ? lmax : lin_v + lmin;
            ssn_pkg::MODE_BOX:        acc13_next = fl_pipe[12].below_cut ? lmin : lmax;
            ssn_pkg::MODE_SCALE:      acc13_next = fl_pipe[12].neg ? -lin_v : lin_v;
            default:                  acc13_next = lmin;
        endcase
    end

    always_comb
    begin
        if (acc13_reg > POS_LIM)
        begin
            level14_next = LW'(POS_LIM);
            clip14_next  = 1'b1;
        end
        else if (acc13_reg < NEG_LIM)
        begin
            level14_next = LW'(NEG_LIM);
            clip14_next  = 1'b1;
        end
        else
        begin
            level14_next = LW'(acc13_reg);
            clip14_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            wsat_pipe[6] <= wsat;
            lin_pipe[6]  <= lin;
            fl_pipe[6]   <= flags;
        end
        // hold side data alongside the logistic lanes
        for (int k = 7; k <= 12; k++)
        begin
            if (en[k])
            begin
                wsat_pipe[k] <= wsat_pipe[k-1];
                lin_pipe[k]  <= lin_pipe[k-1];
                fl_pipe[k]   <= fl_pipe[k-1];
            end
        end
        if (en[12])
            gm12_reg <= gm12[71:30];
        if (en[13])
            acc13_reg <= acc13_next;
        if (en[14])
        begin
            level14_reg <= level14_next;
            clip14_reg  <= clip14_next;
        end
    end

    assign level   = level14_reg;
    assign clipped = clip14_reg;

endmodule
`default_nettype wire

// File: design/selectable_static_nonlinearity_core.sv
// Selectable static nonlinearity core: one signed sample in, one Q16.16 level out.
// Pipeline: 14 register stages; the wide product is split over two stages and each
// logistic lane spans six.
// Throughput: one beat per cycle while out_ready is high; each stage advances when
// empty or when the next advances.
// Reset: valid bits clear and configuration registers take their defaults; the
// logistic table is constant, so no clearing pass is needed.
`default_nettype none
module selectable_static_nonlinearity_core #(
    parameter int IN_FRAC_BITS    = ssn_pkg::IN_FRAC_BITS_DEF,
    parameter int SIG_TABLE_DEPTH = ssn_pkg::SIG_TABLE_DEPTH_DEF,
    parameter int SIG_IN_RANGE    = ssn_pkg::SIG_IN_RANGE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ssn_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [ssn_pkg::PDATA_W-1:0]           pwdata,
    output logic [ssn_pkg::PDATA_W-1:0]                prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [ssn_pkg::SAMPLE_W-1:0]   sample,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [ssn_pkg::LEVEL_W-1:0]         level,
    output logic                                       clipped
);

    localparam int NS = ssn_pkg::NUM_STAGES;
    localparam int DW = ssn_pkg::PDATA_W;

    ssn_pkg::cfg_t      cfg_reg;
    ssn_pkg::reg_idx_t  reg_idx;
    logic               wr_en;

    logic [NS:1]        valid_reg, valid_next;
    ssn_pkg::stage_en_t en;

    logic [ssn_pkg::CAP_W-1:0]  wsat, u1, u2, lin, lane1_u;
    ssn_pkg::flags_t            flags;
    logic                       lane1_neg;
    logic [ssn_pkg::LOGI_W-1:0] l1, l2;

    assign pready  = 1'b1;
    assign reg_idx = ssn_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= ssn_pkg::MODE_SQUARE;
            cfg_reg.level_min  <= 32'sd0;
            cfg_reg.level_max  <= 32'sd3932160;
            cfg_reg.cut_level  <= 23'd20972;
            cfg_reg.gain       <= 40'd196608000;
            cfg_reg.sig_slope  <= 40'd196608000;
            cfg_reg.sig_shift  <= 23'd10486;
            cfg_reg.sig_offset <= 32'sd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ssn_pkg::REG_MODE:       cfg_reg.mode       <= ssn_pkg::mode_t'(pwdata[2:0]);
                ssn_pkg::REG_LEVEL_MIN:  cfg_reg.level_min  <= $signed(pwdata[31:0]);
                ssn_pkg::REG_LEVEL_MAX:  cfg_reg.level_max  <= $signed(pwdata[31:0]);
                ssn_pkg::REG_CUT_LEVEL:  cfg_reg.cut_level  <= pwdata[22:0];
                ssn_pkg::REG_GAIN:       cfg_reg.gain       <= pwdata[39:0];
                ssn_pkg::REG_SIG_SLOPE:  cfg_reg.sig_slope  <= pwdata[39:0];
                ssn_pkg::REG_SIG_SHIFT:  cfg_reg.sig_shift  <= pwdata[22:0];
                ssn_pkg::REG_SIG_OFFSET: cfg_reg.sig_offset <= $signed(pwdata[31:0]);
                default:                 cfg_reg.mode       <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ssn_pkg::REG_MODE:       prdata = DW'(cfg_reg.mode);
            ssn_pkg::REG_LEVEL_MIN:  prdata = DW'(unsigned'(cfg_reg.level_min));
            ssn_pkg::REG_LEVEL_MAX:  prdata = DW'(unsigned'(cfg_reg.level_max));
            ssn_pkg::REG_CUT_LEVEL:  prdata = DW'(cfg_reg.cut_level);
            ssn_pkg::REG_GAIN:       prdata = DW'(cfg_reg.gain);
            ssn_pkg::REG_SIG_SLOPE:  prdata = DW'(cfg_reg.sig_slope);
            ssn_pkg::REG_SIG_SHIFT:  prdata = DW'(cfg_reg.sig_shift);
            ssn_pkg::REG_SIG_OFFSET: prdata = DW'(unsigned'(cfg_reg.sig_offset));
            default:                 prdata = '0;
        endcase
    end

    // stage k advances when empty or when stage k+1 advances
    always_comb
    begin
        logic go;
        go = out_ready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || go;
            go    = en[k];
        end
    end

    always_comb
    begin
        logic [NS:1] prev;
        prev = {valid_reg[NS-1:1], in_valid};
        for (int k = 1; k <= NS; k++)
            valid_next[k] = en[k] ? prev[k] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[1];
    assign out_valid = valid_reg[NS];

    ssn_front #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg_reg),
        .sample (sample),
        .wsat   (wsat),
        .u1     (u1),
        .u2     (u2),
        .lin    (lin),
        .flags  (flags)
    );

    // lane 1 takes slope*x^2 in the square logistic mode
    always_comb
    begin
        if (cfg_reg.mode == ssn_pkg::MODE_SQ_LOGI)
        begin
            lane1_u   = wsat;
            lane1_neg = 1'b0;
        end
        else
        begin
            lane1_u   = u1;
            lane1_neg = flags.d1neg;
        end
    end

    ssn_sig_lane #(
        .SIG_TABLE_DEPTH (SIG_TABLE_DEPTH),
        .SIG_IN_RANGE    (SIG_IN_RANGE)
    ) u_lane1 (
        .clk (clk),
        .en  (en),
        .u   (lane1_u),
        .neg (lane1_neg),
        .l   (l1)
    );

    ssn_sig_lane #(
        .SIG_TABLE_DEPTH (SIG_TABLE_DEPTH),
        .SIG_IN_RANGE    (SIG_IN_RANGE)
    ) u_lane2 (
        .clk (clk),
        .en  (en),
        .u   (u2),
        .neg (flags.d2pos),
        .l   (l2)
    );

    ssn_back u_back (
        .clk     (clk),
        .en      (en),
        .cfg     (cfg_reg),
        .wsat    (wsat),
        .lin     (lin),
        .flags   (flags),
        .l1      (l1),
        .l2      (l2),
        .level   (level),
        .clipped (clipped)
    );

endmodule
`default_nettype wire

// File: tb/ssn_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the selectable static nonlinearity core: tracks register writes on the
// APB port, predicts the level of each sample beat and compares result beats in order.
// Depends on ssn_pkg for widths, modes and register codes.
module ssn_checker
    import ssn_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [PADDR_W-1:0]          paddr,
    input  wire logic [PDATA_W-1:0]          pwdata,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  sample,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic signed [LEVEL_W-1:0]   level,
    input  wire logic                        clipped,
    output int                               errors,
    output int                               pending
);

    localparam int FRAC  = IN_FRAC_BITS_DEF;
    localparam int DEPTH = SIG_TABLE_DEPTH_DEF;
    localparam int RANGE = SIG_IN_RANGE_DEF;
    localparam logic [63:0] CAP = 64'd1 << 60;

    typedef struct {
        logic signed [LEVEL_W-1:0] lvl;
        logic                      clip;
    } level_beat_t;

    mode_t                     cfg_mode;
    logic signed [LEVEL_W-1:0] cfg_min, cfg_max, cfg_offset;
    logic [63:0]               cfg_cut, cfg_gain, cfg_slope, cfg_shift;
    logic [63:0]               logistic_rom [0:DEPTH];
    level_beat_t               levels_due [$];

    function automatic logic [63:0] mul_shr_cap(logic [63:0] a, logic [63:0] b, int n);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> n;
        return (p > {64'd0, CAP}) ? CAP : p[63:0];
    endfunction

    // logistic of +-u, u in Q16, result Q30
    function automatic logic [63:0] logistic(logic neg, logic [63:0] u);
        logic [63:0] v, pos, idx, frac, a, b;
        if (u >= (64'(RANGE) << 16)) begin
            v = logistic_rom[DEPTH];
        end else begin
            pos  = u * DEPTH / RANGE;
            idx  = pos >> 16;
            frac = {48'd0, pos[15:0]};
            if (idx >= DEPTH)
                idx = DEPTH - 1;
            a = logistic_rom[idx];
            b = logistic_rom[idx + 1];
            v = (b >= a) ? a + (((b - a) * frac) >> 16) : a - (((a - b) * frac) >> 16);
        end
        return neg ? (64'd1 << 30) - v : v;
    endfunction

    function automatic logic [63:0] abs_of(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic level_beat_t predict_level(logic signed [SAMPLE_W-1:0] smp);
        level_beat_t r;
        longint      s, d, acc;
        logic [63:0] mag, l1, l2, w;
        s   = smp;
        mag = abs_of(s);
        r.clip = 1'b0;
        case (cfg_mode)
            MODE_SQUARE, MODE_SAT_SQUARE: begin
                acc = $signed(mul_shr_cap(cfg_gain, mag * mag, 2 * FRAC)) + longint'(cfg_min);
                if (cfg_mode == MODE_SAT_SQUARE && acc > longint'(cfg_max))
                    acc = cfg_max;
            end
            MODE_DBL_LOGI: begin
                d  = s - longint'(cfg_shift);
                l1 = logistic(d < 0, (cfg_slope * abs_of(d)) >> FRAC);
                d  = s + longint'(cfg_shift);
                l2 = logistic(d > 0, (cfg_slope * abs_of(d)) >> FRAC);
                acc = $signed(mul_shr_cap(cfg_gain, l1 + l2, 30)) + longint'(cfg_offset)
                    + longint'(cfg_min);
            end
            MODE_SQ_LOGI: begin
                w   = mul_shr_cap(cfg_slope, mag * mag, 2 * FRAC);
                l1  = logistic(1'b0, w);
                acc = $signed(mul_shr_cap(cfg_gain, l1, 30)) + longint'(cfg_offset)
                    + longint'(cfg_min);
            end
            MODE_LINEAR, MODE_SAT_LINEAR: begin
                acc = $signed((cfg_gain * mag) >> FRAC) + longint'(cfg_min);
                if (cfg_mode == MODE_SAT_LINEAR && acc > longint'(cfg_max))
                    acc = cfg_max;
            end
            MODE_BOX: acc = (mag < cfg_cut) ? longint'(cfg_min) : longint'(cfg_max);
            default: begin
                acc = $signed((cfg_gain * mag) >> FRAC);
                if (s < 0)
                    acc = -acc;
            end
        endcase
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            r.clip = 1'b1;
        end
        if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            r.clip = 1'b1;
        end
        r.lvl = acc[31:0];
        return r;
    endfunction

    initial begin
        logic [63:0] t, step, cur, den;
        logic        sub;
        t    = 64'd1 << 56;
        step = t;
        cur  = t;
        sub  = 1'b1;
        for (int k = 1; k <= 40; k++) begin
            t = t * RANGE / (64'(DEPTH) * k);
            step = sub ? step - t : step + t;
            sub = !sub;
        end
        for (int i = 0; i <= DEPTH; i++) begin
            den = (64'd1 << 32) + (cur >> 24);
            logistic_rom[i] = ((64'd1 << 62) + den / 2) / den;
            cur = mul_shr_cap(cur, step, 56);
        end
    end

    assign pending = levels_due.size();

    always @(posedge clk or negedge rst_n) begin
        level_beat_t want;
        if (!rst_n) begin
            cfg_mode   <= MODE_SQUARE;
            cfg_min    <= 0;
            cfg_max    <= 32'sd3932160;
            cfg_cut    <= 64'd20972;
            cfg_gain   <= 64'd196608000;
            cfg_slope  <= 64'd196608000;
            cfg_shift  <= 64'd10486;
            cfg_offset <= 0;
            errors     <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr >> 3))
                    REG_MODE:       cfg_mode   <= mode_t'(pwdata[2:0]);
                    REG_LEVEL_MIN:  cfg_min    <= pwdata[31:0];
                    REG_LEVEL_MAX:  cfg_max    <= pwdata[31:0];
                    REG_CUT_LEVEL:  cfg_cut    <= {41'd0, pwdata[22:0]};
                    REG_GAIN:       cfg_gain   <= {24'd0, pwdata[39:0]};
                    REG_SIG_SLOPE:  cfg_slope  <= {24'd0, pwdata[39:0]};
                    REG_SIG_SHIFT:  cfg_shift  <= {41'd0, pwdata[22:0]};
                    REG_SIG_OFFSET: cfg_offset <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                levels_due.push_back(predict_level(sample));
            if (out_valid && out_ready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: unexpected level beat level=%0d clipped=%0b",
                             $time, level, clipped);
                    errors <= errors + 1;
                end else begin
                    want = levels_due.pop_front();
                    if (want.lvl !== level || want.clip !== clipped) begin
                        $display("%0t: mismatch expected level=%0d clipped=%0b, got level=%0d clipped=%0b",
                                 $time, want.lvl, want.clip, level, clipped);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/selectable_static_nonlinearity_core_tb.sv
`timescale 1ns / 1ps
// Top of the nonlinearity testbench: clock, reset, register phases and sample stimulus.
// Depends on ssn_pkg, the core and ssn_checker, which does all prediction and comparison.
module selectable_static_nonlinearity_core_tb;
    import ssn_pkg::*;

    localparam int PHASES    = 24;
    localparam int PER_PHASE = 32;
    localparam int WATCHDOG  = 3000;

    logic                        clk, rst_n;
    logic                        psel, penable, pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata, prdata;
    logic                        pready;
    logic                        in_valid, in_ready, out_valid, out_ready;
    logic signed [SAMPLE_W-1:0]  sample;
    logic signed [LEVEL_W-1:0]   level;
    logic                        clipped;
    int                          errors, pending;
    int                          burst_left, idle_cycles;
    logic                        long_hold;
    logic [CUT_W-1:0]            cut_now, shift_now;

    selectable_static_nonlinearity_core u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready), .level(level), .clipped(clipped)
    );

    ssn_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready), .level(level), .clipped(clipped),
        .errors(errors), .pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold valid across back-to-back beats; drop it only for a gap between bursts.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 20_000_000)) - 10_000_000);
        endcase
    endfunction

    function automatic logic [39:0] pick_wide();
        case ($urandom_range(0, 5))
            0: return 40'd0;
            1: return {40{1'b1}};
            2: return 40'({$urandom, $urandom} >> $urandom_range(0, 24));
            default: return 40'($urandom_range(1, 1 << 30));
        endcase
    endfunction

    // Receiver: ready pattern with changing bias, plus one long hold-off on request.
    initial begin
        int bias, held;
        held = 0;
        bias = 100;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (long_hold && held == 0) begin
                held = 1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                bias = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
            out_ready <= ($urandom_range(1, 100) <= bias);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int mag;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        sample = '0;
        out_ready = 1'b0;
        long_hold = 1'b0;
        burst_left = 0;
        idle_cycles = 0;
        cut_now = 23'd20972;
        shift_now = 23'd10486;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            // first phase runs on reset defaults
            if (p > 0) begin
                cut_now   = ($urandom_range(0, 4) == 0) ? {CUT_W{1'b1}} :
                            CUT_W'($urandom_range(0, 1 << 21));
                shift_now = ($urandom_range(0, 4) == 0) ? {CUT_W{1'b1}} :
                            CUT_W'($urandom_range(0, 1 << 21));
                write_reg(REG_MODE, PDATA_W'(mode_t'(p % 8)));
                write_reg(REG_LEVEL_MIN, PDATA_W'(pick_level()));
                write_reg(REG_LEVEL_MAX, PDATA_W'(pick_level()));
                write_reg(REG_CUT_LEVEL, PDATA_W'(cut_now));
                write_reg(REG_GAIN, PDATA_W'(pick_wide()));
                write_reg(REG_SIG_SLOPE, PDATA_W'(pick_wide()));
                write_reg(REG_SIG_SHIFT, PDATA_W'(shift_now));
                write_reg(REG_SIG_OFFSET, PDATA_W'(pick_level()));
            end
            if (p == 5)
                long_hold <= 1'b1;
            send_sample(24'sd0);
            send_sample(24'sd1);
            send_sample(-24'sd1);
            send_sample(24'sh7FFFFF);
            send_sample(24'sh800000);
            send_sample($signed({1'b0, cut_now}));
            send_sample($signed({1'b0, cut_now}) - 24'sd1);
            send_sample(-$signed({1'b0, cut_now}));
            send_sample($signed({1'b0, shift_now}));
            send_sample(-$signed({1'b0, shift_now}));
            for (int i = 0; i < PER_PHASE; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_sample(SAMPLE_W'($urandom));
                end else begin
                    mag = $urandom_range(0, 1 << $urandom_range(4, 22));
                    send_sample($urandom_range(0, 1) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag));
                end
            end
            wait_drained();
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
